// ===== src/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// token codes, stack geometry and the structs passed between modules
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int VALUE_BITS  = 32;
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // input token kinds
   localparam logic [2:0] KIND_NUM    = 3'd0;
   localparam logic [2:0] KIND_OP     = 3'd1;
   localparam logic [2:0] KIND_LPAREN = 3'd2;
   localparam logic [2:0] KIND_RPAREN = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   // stack entry for an open parenthesis, operators use codes 0 to 3
   localparam logic [2:0] ENTRY_PAREN = 3'd4;

   // result kinds
   localparam logic [1:0] OUT_NUM = 2'd0;
   localparam logic [1:0] OUT_OP  = 2'd1;
   localparam logic [1:0] OUT_END = 2'd2;
   localparam logic [1:0] OUT_ERR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_CLOSE    = 2'd1;
   localparam logic [1:0] ERR_OPEN     = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   typedef struct packed {
      logic                  wr_en;
      logic [PTR_W-1:0]      wr_addr;
      logic [2:0]            wr_data;
      logic                  rd_en;
      logic [PTR_W-1:0]      rd_addr;
   } itp_mem_req_type;

   typedef struct packed {
      logic [1:0]                   out_kind;
      logic [1:0]                   out_op;
      logic signed [VALUE_BITS-1:0] out_value;
      logic [1:0]                   error_code;
      logic                         last;
   } itp_result_type;

endpackage

// ===== src/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard token converter
// timing: a token is registered in idle; a number or overflow error beat is
//   loaded into the rsp register from the exam state, any other error beat
//   from the tail state; a popped operator waits in the holding register
// flow: tokens are taken only in idle, once the last token's beats are loaded;
//   each operator popped off the stack takes one stack memory read, the last
//   popped one leaves the holding register in tail before any error or end beat
// reset: state, stack count, error flag and pending flags cleared, stack memory keeps its contents
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [2:0]                             req_kind,
   input  logic [1:0]                             req_op_code,
   input  logic signed [itp_pkg::VALUE_BITS-1:0]  req_num_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_out_kind,
   output logic [1:0]                             rsp_out_op,
   output logic signed [itp_pkg::VALUE_BITS-1:0]  rsp_out_value,
   output logic [1:0]                             rsp_error_code,
   output logic                                   rsp_last
);
   import itp_pkg::*;

   // idle waits for a token, exam looks at the stack top each cycle,
   // tail drains the held operator, error and end beats
   typedef enum logic [1:0] {ST_IDLE, ST_EXAM, ST_TAIL} state_type;

   state_type                     state_ff, state_in;
   logic [2:0]                    kind_ff, kind_in;
   logic [1:0]                    op_ff, op_in;
   logic signed [VALUE_BITS-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          hold_ff, hold_in;
   // popped operator held back until we know whether it is the last beat
   logic                          pend_valid_ff, pend_valid_in;
   logic [1:0]                    pend_op_ff, pend_op_in;
   logic                          do_err_ff, do_err_in;
   logic [1:0]                    err_code_ff, err_code_in;
   logic                          do_end_ff, do_end_in;

   itp_mem_req_type               mem_req;
   logic [2:0]                    top;
   itp_result_type                res;
   logic                          res_load;
   logic                          emit_ok;

   logic [CNT_W-1:0]              cnt_m1;
   logic [CNT_W-1:0]              cnt_m2;
   logic                          top_valid;
   logic                          top_paren;
   logic                          full;
   logic                          pop_cond;
   logic                          req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign cnt_m1    = count_ff - CNT_W'(1);
   assign cnt_m2    = count_ff - CNT_W'(2);
   assign top_valid = (count_ff != '0);
   assign top_paren = (top == ENTRY_PAREN);
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));

   // an operator pops a stacked one of equal or higher precedence,
   // a close paren or the end marker pop anything but an open paren
   assign pop_cond = top_valid && !top_paren &&
                     ((kind_ff != KIND_OP) || !(op_ff[1] && !top[1]));

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      hold_in       = hold_ff;
      pend_valid_in = pend_valid_ff;
      pend_op_in    = pend_op_ff;
      do_err_in     = do_err_ff;
      err_code_in   = err_code_ff;
      do_end_in     = do_end_ff;

      mem_req         = '0;
      mem_req.rd_addr = cnt_m1[PTR_W-1:0];
      mem_req.wr_addr = count_ff[PTR_W-1:0];
      mem_req.wr_data = {1'b0, op_ff};

      res_load = 1'b0;
      res      = '0;

      case (state_ff)
         ST_IDLE: begin
            // unknown kinds, and non-end tokens while in error, are dropped here
            if (req_take && (req_kind <= KIND_END) &&
                !(hold_ff && (req_kind != KIND_END))) begin
               kind_in        = req_kind;
               op_in          = req_op_code;
               value_in       = req_num_value;
               mem_req.rd_en  = 1'b1;
               state_in       = ST_EXAM;
            end
         end

         ST_EXAM: begin
            if (kind_ff == KIND_NUM) begin
               if (emit_ok) begin
                  res_load      = 1'b1;
                  res.out_kind  = OUT_NUM;
                  res.out_value = value_ff;
                  res.last      = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (kind_ff == KIND_LPAREN) begin
               if (full) begin
                  if (emit_ok) begin
                     res_load       = 1'b1;
                     res.out_kind   = OUT_ERR;
                     res.error_code = ERR_OVERFLOW;
                     res.last       = 1'b1;
                     count_in       = '0;
                     hold_in        = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = ENTRY_PAREN;
                  count_in        = count_ff + CNT_W'(1);
                  state_in        = ST_IDLE;
               end
            end else if (pop_cond) begin
               // pop one operator, fetch the entry below for next cycle
               if (!pend_valid_ff || emit_ok) begin
                  if (pend_valid_ff) begin
                     res_load     = 1'b1;
                     res.out_kind = OUT_OP;
                     res.out_op   = pend_op_ff;
                  end
                  pend_valid_in   = 1'b1;
                  pend_op_in      = top[1:0];
                  count_in        = cnt_m1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = cnt_m2[PTR_W-1:0];
               end
            end else if (kind_ff == KIND_OP) begin
               if (pend_valid_ff) begin
                  // after a pop the push always fits
                  mem_req.wr_en = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  do_err_in     = 1'b0;
                  do_end_in     = 1'b0;
                  state_in      = ST_TAIL;
               end else if (full) begin
                  if (emit_ok) begin
                     res_load       = 1'b1;
                     res.out_kind   = OUT_ERR;
                     res.error_code = ERR_OVERFLOW;
                     res.last       = 1'b1;
                     count_in       = '0;
                     hold_in        = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  mem_req.wr_en = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  state_in      = ST_IDLE;
               end
            end else if (kind_ff == KIND_RPAREN) begin
               do_end_in = 1'b0;
               if (top_valid) begin
                  // matching open paren found, drop it
                  count_in  = cnt_m1;
                  do_err_in = 1'b0;
                  state_in  = pend_valid_ff ? ST_TAIL : ST_IDLE;
               end else begin
                  count_in    = '0;
                  hold_in     = 1'b1;
                  do_err_in   = 1'b1;
                  err_code_in = ERR_CLOSE;
                  state_in    = ST_TAIL;
               end
            end else begin
               // end marker: leftover open paren is an error, then end beat
               do_err_in   = top_valid;
               err_code_in = ERR_OPEN;
               do_end_in   = 1'b1;
               count_in    = '0;
               hold_in     = 1'b0;
               state_in    = ST_TAIL;
            end
         end

         ST_TAIL: begin
            if (emit_ok) begin
               res_load = 1'b1;
               if (pend_valid_ff) begin
                  res.out_kind  = OUT_OP;
                  res.out_op    = pend_op_ff;
                  res.last      = !(do_err_ff || do_end_ff);
                  pend_valid_in = 1'b0;
                  if (!(do_err_ff || do_end_ff)) begin
                     state_in = ST_IDLE;
                  end
               end else if (do_err_ff) begin
                  res.out_kind   = OUT_ERR;
                  res.error_code = err_code_ff;
                  res.last       = !do_end_ff;
                  do_err_in      = 1'b0;
                  if (!do_end_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  res.out_kind = OUT_END;
                  res.last     = 1'b1;
                  do_end_in    = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         hold_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         do_err_ff     <= 1'b0;
         do_end_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_ff       <= hold_in;
         pend_valid_ff <= pend_valid_in;
         do_err_ff     <= do_err_in;
         do_end_ff     <= do_end_in;
      end
      kind_ff     <= kind_in;
      op_ff       <= op_in;
      value_ff    <= value_in;
      pend_op_ff  <= pend_op_in;
      err_code_ff <= err_code_in;
   end

   itp_stack_mem u_stack_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (top)
   );

   itp_rsp_reg u_rsp_reg (
      .clock          (clock),
      .reset          (reset),
      .load           (res_load),
      .load_data      (res),
      .load_ok        (emit_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_op     (rsp_out_op),
      .rsp_out_value  (rsp_out_value),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // stack never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // while in error the stack is empty
   a_hold_empty: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (count_ff == '0))
      else $error("error hold with stacked entries");

   // a result is only loaded when the output register can take it
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      res_load |-> emit_ok)
      else $error("result loaded over a stalled beat");

   // the final beat of a token returns the block to taking tokens
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (res_load && res.last) |=> req_ready)
      else $error("not ready after last beat");

   // the held operator is never dropped on the way back to idle
   a_pend_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held operator left in idle");

endmodule

// ===== src/itp_stack_mem.sv =====
// ----------------------------------------------------------------------------
// itp_stack_mem: operator stack storage
// one write and one registered read per cycle, read data holds without rd_en
// ----------------------------------------------------------------------------
module itp_stack_mem (
   input  logic                     clock,
   input  itp_pkg::itp_mem_req_type mem_req,
   output logic [2:0]               rd_data
);
   import itp_pkg::*;

   logic [2:0] mem_ff [STACK_DEPTH];
   logic [2:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/itp_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// itp_rsp_reg: result output register
// holds one result beat, takes a new one when empty or while the current beat is taken
// ----------------------------------------------------------------------------
module itp_rsp_reg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  itp_pkg::itp_result_type                load_data,
   output logic                                   load_ok,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_out_kind,
   output logic [1:0]                             rsp_out_op,
   output logic signed [itp_pkg::VALUE_BITS-1:0]  rsp_out_value,
   output logic [1:0]                             rsp_error_code,
   output logic                                   rsp_last
);
   import itp_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   itp_result_type data_ff;

   assign load_ok  = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_kind   = data_ff.out_kind;
   assign rsp_out_op     = data_ff.out_op;
   assign rsp_out_value  = data_ff.out_value;
   assign rsp_error_code = data_ff.error_code;
   assign rsp_last       = data_ff.last;

endmodule

// ===== sim/infix_to_postfix_converter_tb.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb: self-checking bench for the shunting-yard converter
// drives a short table of hand-picked tokens and then random expressions
// (well-formed, deeply nested, broken and pure noise) under bursty sending and
// a changing rsp stall pattern; every rsp beat is checked field by field
// against its typed table row or an in-bench postfix predictor
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
   import itp_pkg::*;

   // operator codes, same encoding on req and rsp
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // token kinds the block must ignore
   localparam logic [2:0] KIND_JUNK_LO = 3'd5;
   localparam logic [2:0] KIND_JUNK_HI = 3'd7;

   // receiver stall modes
   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_SPARSE = 2;
   localparam int STALL_LONG   = 3;

   // random expression styles
   localparam int EXPR_CLEAN  = 0;
   localparam int EXPR_DEEP   = 1;
   localparam int EXPR_BROKEN = 2;
   localparam int EXPR_NOISE  = 3;

   localparam int LIVE_ITEMS   = 220;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 16;
   localparam int CLK_PERIOD   = 12;
   localparam int LIMIT_CYCLES = 1_500_000;

   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [2:0]                   kind;
      logic [1:0]                   op;
      logic signed [VALUE_BITS-1:0] value;
   } infix_tok_type;

   // one row of the hand-written table; want is only used when typed is set
   typedef struct {
      infix_tok_type  tok;
      bit             typed;
      itp_result_type want;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [2:0]                    req_kind = '0;
   logic [1:0]                    req_op_code = '0;
   logic signed [VALUE_BITS-1:0]  req_num_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_out_kind;
   logic [1:0]                    rsp_out_op;
   logic signed [VALUE_BITS-1:0]  rsp_out_value;
   logic [1:0]                    rsp_error_code;
   logic                          rsp_last;

   infix_to_postfix_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_op_code    (req_op_code),
      .req_num_value  (req_num_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_op     (rsp_out_op),
      .rsp_out_value  (rsp_out_value),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // postfix predictor: its own operator stack, depth and error flag
   // ---------------------------------------------------------------------------
   logic [2:0]     rpn_stack [STACK_DEPTH];
   int             rpn_depth = 0;
   bit             rpn_in_error = 1'b0;
   itp_result_type rpn_burst [$];     // beats caused by the token just predicted
   itp_result_type postfix_due [$];   // beats the block still owes us

   // hard stop well past the slowest legal run
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("timeout: %0d postfix beats still outstanding", postfix_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int prec_of(input logic [2:0] entry);
      return (entry >= {1'b0, OP_MUL}) ? 2 : 1;
   endfunction

   function automatic void rpn_emit(input logic [1:0] k, input logic [1:0] op,
                                    input logic signed [VALUE_BITS-1:0] v,
                                    input logic [1:0] err);
      itp_result_type r;
      r.out_kind   = k;
      r.out_op     = op;
      r.out_value  = v;
      r.error_code = err;
      r.last       = 1'b0;
      rpn_burst.push_back(r);
   endfunction

   function automatic void rpn_fail(input logic [1:0] code);
      rpn_emit(OUT_ERR, 2'd0, '0, code);
      rpn_depth    = 0;
      rpn_in_error = 1'b1;
   endfunction

   function automatic void rpn_push(input logic [2:0] entry);
      if (rpn_depth >= STACK_DEPTH) begin
         rpn_fail(ERR_OVERFLOW);
      end else begin
         rpn_stack[rpn_depth] = entry;
         rpn_depth++;
      end
   endfunction

   // fills rpn_burst with the beats one token causes; flags tokens the block ignores
   function automatic void rpn_predict(input infix_tok_type t, output bit ignored);
      logic [2:0] top;
      bit         stop;
      rpn_burst.delete();
      ignored = 1'b0;
      if (t.kind > KIND_END || (rpn_in_error && t.kind != KIND_END)) begin
         ignored = 1'b1;
         return;
      end
      case (t.kind)
         KIND_NUM: begin
            rpn_emit(OUT_NUM, 2'd0, t.value, ERR_NONE);
         end
         KIND_OP: begin
            stop = 1'b0;
            while (rpn_depth > 0 && !stop) begin
               top = rpn_stack[rpn_depth-1];
               if (top == ENTRY_PAREN || prec_of({1'b0, t.op}) > prec_of(top)) begin
                  stop = 1'b1;
               end else begin
                  rpn_emit(OUT_OP, top[1:0], '0, ERR_NONE);
                  rpn_depth--;
               end
            end
            rpn_push({1'b0, t.op});
         end
         KIND_LPAREN: begin
            rpn_push(ENTRY_PAREN);
         end
         KIND_RPAREN: begin
            while (rpn_depth > 0 && rpn_stack[rpn_depth-1] != ENTRY_PAREN) begin
               rpn_emit(OUT_OP, rpn_stack[rpn_depth-1][1:0], '0, ERR_NONE);
               rpn_depth--;
            end
            if (rpn_depth > 0) rpn_depth--;
            else rpn_fail(ERR_CLOSE);
         end
         default: begin
            // end marker: flush, an open paren left behind is an error
            stop = 1'b0;
            while (!rpn_in_error && rpn_depth > 0 && !stop) begin
               top = rpn_stack[rpn_depth-1];
               if (top == ENTRY_PAREN) begin
                  rpn_emit(OUT_ERR, 2'd0, '0, ERR_OPEN);
                  stop = 1'b1;
               end else begin
                  rpn_emit(OUT_OP, top[1:0], '0, ERR_NONE);
                  rpn_depth--;
               end
            end
            rpn_emit(OUT_END, 2'd0, '0, ERR_NONE);
            rpn_depth    = 0;
            rpn_in_error = 1'b0;
         end
      endcase
      if (rpn_burst.size() > 0) rpn_burst[rpn_burst.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------------
   int burst_left = 0;
   int tokens_sent = 0;
   int tokens_live = 0;

   function automatic infix_tok_type mk_tok(input logic [2:0] k, input logic [1:0] op,
                                            input logic signed [VALUE_BITS-1:0] v);
      infix_tok_type t;
      t.kind  = k;
      t.op    = op;
      t.value = v;
      return t;
   endfunction

   // one req beat, then the expected beats it causes; typed rows bring their own
   task automatic feed_token(input infix_tok_type t, input bit typed,
                             input itp_result_type want);
      int gap;
      bit ignored;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_kind      <= t.kind;
      req_op_code   <= t.op;
      req_num_value <= t.value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge
      rpn_predict(t, ignored);
      tokens_sent++;
      if (!ignored) tokens_live++;
      if (typed) postfix_due.push_back(want);
      else foreach (rpn_burst[i]) postfix_due.push_back(rpn_burst[i]);
   endtask

   // sender holds off until the block has handed over every owed beat
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (postfix_due.size() != 0);
      burst_left = 0;
   endtask

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // builds one random expression and sends it
   task automatic run_expression(input int style);
      infix_tok_type  toks [$];
      itp_result_type none;
      int             operands;
      int             depth;
      int             depth_cap;
      none = '0;
      depth = 0;
      depth_cap = 4;
      operands = $urandom_range(1, 8);
      if (style == EXPR_NOISE) begin
         repeat ($urandom_range(1, 8)) begin
            toks.push_back(mk_tok(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                  pick_value()));
         end
      end else begin
         if (style == EXPR_DEEP) begin
            // deep nesting, enough to hit the stack limit now and then
            depth_cap = $urandom_range(14, 18);
            repeat (depth_cap) toks.push_back(mk_tok(KIND_LPAREN, 2'd0, '0));
            depth = depth_cap;
         end
         forever begin
            while (depth < depth_cap && $urandom_range(0, 3) == 0) begin
               toks.push_back(mk_tok(KIND_LPAREN, 2'($urandom_range(0, 3)), '0));
               depth++;
            end
            toks.push_back(mk_tok(KIND_NUM, 2'($urandom_range(0, 3)), pick_value()));
            operands--;
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
               toks.push_back(mk_tok(KIND_RPAREN, 2'd0, '0));
               depth--;
            end
            if (operands == 0) break;
            toks.push_back(mk_tok(KIND_OP, 2'($urandom_range(0, 3)), pick_value()));
         end
         if (style == EXPR_BROKEN) begin
            case ($urandom_range(0, 2))
               0: depth = depth + 1;                 // extra close paren
               1: if (depth == 0) toks.push_front(mk_tok(KIND_LPAREN, 2'd0, '0));
               default: depth = 0;                   // leave opens dangling
            endcase
         end
         repeat (depth) toks.push_back(mk_tok(KIND_RPAREN, 2'd0, '0));
      end
      toks.push_back(mk_tok(KIND_END, 2'($urandom_range(0, 3)), pick_value()));
      foreach (toks[i]) feed_token(toks[i], 1'b0, none);
   endtask

   // ---------------------------------------------------------------------------
   // receiver stall pattern and rsp beat checker
   // ---------------------------------------------------------------------------
   int fault_cnt = 0;
   int beats_checked = 0;
   int error_beats = 0;
   int overflow_beats = 0;
   int stall_mode = STALL_NONE;
   int mode_left = 0;
   int stall_left = 0;

   function automatic void note_fault(input string what);
      fault_cnt++;
      if (fault_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin
      itp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (rsp_out_kind == OUT_ERR) error_beats++;
         if (rsp_out_kind == OUT_ERR && rsp_error_code == ERR_OVERFLOW) overflow_beats++;
         if (postfix_due.size() == 0) begin
            note_fault($sformatf("unexpected beat kind %0d op %0d value %0d err %0d last %0d",
                                 rsp_out_kind, rsp_out_op, rsp_out_value,
                                 rsp_error_code, rsp_last));
         end else begin
            want = postfix_due.pop_front();
            if (rsp_out_kind !== want.out_kind || rsp_out_op !== want.out_op ||
                rsp_out_value !== want.out_value || rsp_error_code !== want.error_code ||
                rsp_last !== want.last) begin
               note_fault($sformatf({"want kind %0d op %0d value %0d err %0d last %0d, ",
                                     "got kind %0d op %0d value %0d err %0d last %0d"},
                                    want.out_kind, want.out_op, want.out_value,
                                    want.error_code, want.last, rsp_out_kind, rsp_out_op,
                                    rsp_out_value, rsp_error_code, rsp_last));
            end
         end
      end
      // pick a fresh stall mode every so often
      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
         mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:   rsp_ready <= 1'b1;
         STALL_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   function automatic plan_row_type row_free(input logic [2:0] k, input logic [1:0] op,
                                             input logic signed [VALUE_BITS-1:0] v);
      plan_row_type r;
      r.tok   = mk_tok(k, op, v);
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   // row with its single beat written out, always the last one of its token
   function automatic plan_row_type row_typed(input logic [2:0] k, input logic [1:0] op,
                                              input logic signed [VALUE_BITS-1:0] v,
                                              input logic [1:0] out_k,
                                              input logic signed [VALUE_BITS-1:0] out_v,
                                              input logic [1:0] err);
      plan_row_type r;
      r.tok              = mk_tok(k, op, v);
      r.typed            = 1'b1;
      r.want.out_kind    = out_k;
      r.want.out_op      = 2'd0;
      r.want.out_value   = out_v;
      r.want.error_code  = err;
      r.want.last        = 1'b1;
      return r;
   endfunction

   plan_row_type plan [$];

   initial begin
      int exprs;
      int style;
      int dice;
      plan = '{
         // numbers at the extremes pass straight through
         row_typed(KIND_NUM, OP_DIV, VAL_MAX, OUT_NUM, VAL_MAX, ERR_NONE),
         row_typed(KIND_END, OP_ADD, '0, OUT_END, '0, ERR_NONE),
         row_typed(KIND_NUM, OP_ADD, VAL_MIN, OUT_NUM, VAL_MIN, ERR_NONE),
         // close paren on an empty stack, then tokens swallowed until the end marker
         row_typed(KIND_RPAREN, OP_ADD, '0, OUT_ERR, '0, ERR_CLOSE),
         row_free(KIND_NUM, OP_ADD, 32'sd77),
         row_free(KIND_OP, OP_DIV, '0),
         row_typed(KIND_END, OP_DIV, '1, OUT_END, '0, ERR_NONE),
         // unknown kinds are dropped
         row_free(KIND_JUNK_HI, OP_DIV, '1),
         row_free(KIND_JUNK_LO, OP_SUB, VAL_MIN),
         // 5 + 0 * -1 - ( 3 / 9 ) + 4 ) : precedence pops, paren pops, stray close
         row_free(KIND_NUM, OP_ADD, 32'sd5),
         row_free(KIND_OP, OP_ADD, '0),
         row_free(KIND_NUM, OP_ADD, '0),
         row_free(KIND_OP, OP_MUL, '0),
         row_free(KIND_NUM, OP_ADD, '1),
         row_free(KIND_OP, OP_SUB, '0),
         row_free(KIND_LPAREN, OP_ADD, '0),
         row_free(KIND_NUM, OP_ADD, 32'sd3),
         row_free(KIND_OP, OP_DIV, '0),
         row_free(KIND_NUM, OP_ADD, 32'sd9),
         row_free(KIND_RPAREN, OP_ADD, '0),
         row_free(KIND_OP, OP_ADD, '0),
         row_free(KIND_NUM, OP_ADD, 32'sd4),
         row_free(KIND_RPAREN, OP_ADD, '0),
         row_typed(KIND_END, OP_ADD, '0, OUT_END, '0, ERR_NONE),
         // ( 6 * 2 <end> : open paren left at flush
         row_free(KIND_LPAREN, OP_ADD, '0),
         row_free(KIND_NUM, OP_ADD, 32'sd6),
         row_free(KIND_OP, OP_MUL, '0),
         row_free(KIND_NUM, OP_ADD, 32'sd2),
         row_free(KIND_END, OP_ADD, '0)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) feed_token(plan[i].tok, plan[i].typed, plan[i].want);
      hold_until_drained();

      exprs = 0;
      while (tokens_sent < LIVE_ITEMS) begin
         dice = $urandom_range(0, 9);
         if (dice < 6) style = EXPR_CLEAN;
         else if (dice < 7) style = EXPR_DEEP;
         else if (dice < 9) style = EXPR_BROKEN;
         else style = EXPR_NOISE;
         run_expression(style);
         exprs++;
         if (exprs % 8 == 0) hold_until_drained();
      end

      req_valid <= 1'b0;
      while (postfix_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (postfix_due.size() != 0) note_fault("beats still owed at the end");

      $display("%0d tokens sent (%0d acted on) over %0d random expressions", tokens_sent,
               tokens_live, exprs);
      $display("%0d postfix beats checked, %0d error beats of which %0d overflows, %0d faults",
               beats_checked, error_beats, overflow_beats, fault_cnt);
      if (fault_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/itp_pkg.sv
src/itp_stack_mem.sv
src/itp_rsp_reg.sv
src/infix_to_postfix_converter.sv
sim/infix_to_postfix_converter_tb.sv
